>>> hdl/imh_pkg.sv
`timescale 1ns / 1ps
package imh_pkg;
  localparam logic [2:0] OP_UPDATE   = 3'd0;
  localparam logic [2:0] OP_DECREASE = 3'd1;
  localparam logic [2:0] OP_REMOVE   = 3'd2;
  localparam logic [2:0] OP_EXTRACT  = 3'd3;
  localparam logic [2:0] OP_QUERY    = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  localparam int KEY_W = 10;
  localparam int IN_VAL_W = 32;
  localparam int CNT_W = 11;
endpackage

>>> hdl/imh_ram.sv
`timescale 1ns / 1ps
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/indexed_min_heap_decrease_key_top.sv
`timescale 1ns / 1ps
// Indexed binary min-heap with decrease-key. One transaction in gives one
// transaction out. Each operation is run by a sequencer over four simple
// dual-port RAMs (heap slots, key values, key positions, presence) with one read
// and one write per RAM per cycle. A raise of a key's value is done as a remove
// then an insert, and a result is held until the output takes it.
// After reset the presence RAM is cleared, one entry per cycle, before the
// first transaction is accepted.
module indexed_min_heap_decrease_key_top #(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // operation[2:0], key[12:3], new_value[44:13], amount[76:45], zeros to 79
  input  logic [79:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_key[9:0], out_value[41:10], count[52:42], present[53], status[55:54]
  output logic [55:0]  m_tdata
);
  localparam int AW = $clog2(CAPACITY);
  localparam int KW = imh_pkg::KEY_W;
  localparam int VW = VALUE_WIDTH;
  localparam int CW = AW + 1;
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE = 5'd1,  S_LOOK = 5'd2,
                         S_DISP = 5'd3,   S_SET = 5'd4,   S_UP_RD = 5'd5,
                         S_UP_W1 = 5'd6,  S_UP_W2 = 5'd7, S_UP_CMP = 5'd8,
                         S_UP_SW = 5'd9,  S_UP_SW2 = 5'd10, S_EXT = 5'd11,
                         S_EXT_W = 5'd12, S_EXT_W2 = 5'd13, S_DN_RD = 5'd14,
                         S_DN_W = 5'd15,  S_DN_CMP = 5'd16, S_DN_SW = 5'd17,
                         S_DN_SW2 = 5'd18, S_INS = 5'd19,  S_FIN = 5'd20,
                         S_FIN_W = 5'd21, S_FIN_W2 = 5'd22, S_OUT = 5'd23,
                         S_ROOT = 5'd24;

  // after a sift-up or sift-down finishes, what to do next
  localparam logic [1:0] AF_DONE = 2'd0, AF_EXTRACT = 2'd1, AF_REINSERT = 2'd2;

  logic [4:0] state;

  logic [2:0]  op;
  logic [KW-1:0] key;
  logic signed [VW-1:0] nv;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_m1;
  logic [1:0] status;
  logic [1:0] after;
  logic       extracted;
  logic [KW-1:0] ok_key;
  logic signed [VW-1:0] ok_val;
  logic [AW:0] cur, other;
  logic [AW:0] lchild, rchild;
  logic [2:0]  rd_phase;
  logic signed [VW-1:0] vc, vl, vr;
  logic [KW-1:0] kc, kl, kr;
  logic       key_ok;
  logic [AW:0] clr;
  // value to insert, kept while the key is removed
  logic signed [VW-1:0] saved_nv;

  // RAM ports
  logic          hs_we, kv_we, kp_we, pr_we;
  logic [AW-1:0] hs_wa, hs_ra, kv_wa, kv_ra, kp_wa, kp_ra, pr_wa, pr_ra;
  logic [KW-1:0] hs_wd, hs_rd;
  logic [VW-1:0] kv_wd, kv_rd;
  logic [AW-1:0] kp_wd, kp_rd;
  logic          pr_wd, pr_rd;

  imh_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_slots (.clk, .we(hs_we), .waddr(hs_wa),
    .wdata(hs_wd), .raddr(hs_ra), .rdata(hs_rd));
  imh_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_vals (.clk, .we(kv_we), .waddr(kv_wa),
    .wdata(kv_wd), .raddr(kv_ra), .rdata(kv_rd));
  imh_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_pos (.clk, .we(kp_we), .waddr(kp_wa),
    .wdata(kp_wd), .raddr(kp_ra), .rdata(kp_rd));
  imh_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_pres (.clk, .we(pr_we), .waddr(pr_wa),
    .wdata(pr_wd), .raddr(pr_ra), .rdata(pr_rd));

  // input decode
  logic [2:0]  in_op;
  logic [KW-1:0] in_key;
  logic signed [imh_pkg::IN_VAL_W-1:0] in_nv, in_amt;
  assign in_op  = s_tdata[2:0];
  assign in_key = s_tdata[12:3];
  assign in_nv  = s_tdata[44:13];
  assign in_amt = s_tdata[76:45];

  logic signed [imh_pkg::IN_VAL_W-1:0] amt;
  logic signed [VW+32:0] wide_nv, wide_sub, wide_dec;
  logic signed [VW-1:0] clamp_nv, dec_val, minm1;

  assign s_tready = (state == S_IDLE);

  function automatic logic signed [VW-1:0] clampw(input logic signed [VW+32:0] v);
    if (v > $signed({{34{1'b0}}, VMAX[VW-2:0]})) return VMAX;
    if (v < -$signed({{33{1'b0}}, 1'b1, {(VW-1){1'b0}}})) return VMIN;
    return v[VW-1:0];
  endfunction

  assign wide_nv  = (VW+33)'(in_nv);
  assign clamp_nv = clampw(wide_nv);
  assign wide_dec = (VW+33)'($signed(kv_rd)) - (VW+33)'(amt);
  assign dec_val  = clampw(wide_dec);
  assign wide_sub = (VW+33)'($signed(kv_rd)) - (VW+33)'(1);
  assign minm1    = clampw(wide_sub);

  assign lchild = {cur[AW-1:0], 1'b1};
  assign rchild = lchild + (AW+1)'(1);
  assign cnt_m1 = cnt - CW'(1);

  // one-hot-ish RAM read and write port mux built in comb from state
  always_comb begin
    hs_we = 1'b0; kv_we = 1'b0; kp_we = 1'b0; pr_we = 1'b0;
    hs_wa = '0; kv_wa = '0; kp_wa = '0; pr_wa = '0;
    hs_wd = '0; kv_wd = '0; kp_wd = '0; pr_wd = 1'b0;
    hs_ra = '0; kv_ra = '0; kp_ra = '0; pr_ra = '0;
    case (state)
      S_CLEAR: begin
        pr_we = 1'b1; pr_wa = clr[AW-1:0];
      end
      S_IDLE: begin
        pr_ra = in_key[AW-1:0]; kv_ra = in_key[AW-1:0]; kp_ra = in_key[AW-1:0];
      end
      S_LOOK: begin
        pr_ra = key[AW-1:0]; kv_ra = key[AW-1:0]; kp_ra = key[AW-1:0];
      end
      S_SET: begin
        kv_we = 1'b1; kv_wa = key[AW-1:0]; kv_wd = nv;
      end
      S_UP_RD: begin
        hs_ra = cur[AW-1:0];
      end
      S_UP_W1: begin
        hs_ra = other[AW-1:0]; kv_ra = hs_rd[AW-1:0];
      end
      S_UP_W2: begin
        kv_ra = hs_rd[AW-1:0];
      end
      S_UP_SW, S_DN_SW: begin
        hs_we = 1'b1; hs_wa = cur[AW-1:0]; hs_wd = kl;
        kp_we = 1'b1; kp_wa = kl[AW-1:0]; kp_wd = cur[AW-1:0];
      end
      S_UP_SW2, S_DN_SW2: begin
        hs_we = 1'b1; hs_wa = other[AW-1:0]; hs_wd = kc;
        kp_we = 1'b1; kp_wa = kc[AW-1:0]; kp_wd = other[AW-1:0];
      end
      S_EXT: begin
        hs_ra = '0;
      end
      S_EXT_W: begin
        pr_we = 1'b1; pr_wa = hs_rd[AW-1:0]; pr_wd = 1'b0;
        kv_ra = hs_rd[AW-1:0];
        hs_ra = cnt_m1[AW-1:0];
      end
      S_EXT_W2: begin
        if (cnt != '0) begin
          hs_we = 1'b1; hs_wa = '0; hs_wd = hs_rd;
          kp_we = 1'b1; kp_wa = hs_rd[AW-1:0]; kp_wd = '0;
        end
      end
      S_DN_RD, S_DN_W: begin
        hs_ra = (rd_phase == 3'd0) ? cur[AW-1:0] :
                (rd_phase == 3'd1) ? lchild[AW-1:0] : rchild[AW-1:0];
        kv_ra = hs_rd[AW-1:0];
      end
      S_INS: begin
        kv_we = 1'b1; kv_wa = key[AW-1:0]; kv_wd = saved_nv;
        pr_we = 1'b1; pr_wa = key[AW-1:0]; pr_wd = 1'b1;
        hs_we = 1'b1; hs_wa = cnt[AW-1:0]; hs_wd = key;
        kp_we = 1'b1; kp_wa = key[AW-1:0]; kp_wd = cnt[AW-1:0];
      end
      S_FIN: begin
        hs_ra = '0; pr_ra = key[AW-1:0];
      end
      S_FIN_W: begin
        kv_ra = hs_rd[AW-1:0];
      end
      S_ROOT: begin
        hs_ra = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + (AW+1)'(1);
          if (clr == (AW+1)'(CAPACITY - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op <= in_op; key <= in_key; nv <= clamp_nv;
            amt <= in_amt;
            key_ok <= ({{(32-KW){1'b0}}, in_key} < 32'(CAPACITY));
            status <= imh_pkg::ST_OK; extracted <= 1'b0;
            state <= S_LOOK;
          end
        end
        S_LOOK: state <= S_DISP;
        S_DISP: begin
          cur <= {1'b0, kp_rd};
          after <= AF_DONE;
          state <= S_FIN;
          case (op)
            imh_pkg::OP_UPDATE: begin
              if (!key_ok) status <= imh_pkg::ST_ABSENT;
              else if (!pr_rd) begin
                if (cnt >= CW'(CAPACITY)) status <= imh_pkg::ST_FULL;
                else state <= S_INS;
              end else if ($signed(kv_rd) > nv) state <= S_SET;
              else if ($signed(kv_rd) < nv) begin
                after <= AF_REINSERT; state <= S_ROOT;
              end
            end
            imh_pkg::OP_DECREASE: begin
              if (!(key_ok && pr_rd)) status <= imh_pkg::ST_ABSENT;
              else begin
                nv <= dec_val;
                if (amt < 0) begin
                  after <= AF_REINSERT; state <= S_ROOT;
                end else state <= S_SET;
              end
            end
            imh_pkg::OP_REMOVE: begin
              if (!(key_ok && pr_rd)) status <= imh_pkg::ST_ABSENT;
              else begin
                after <= AF_EXTRACT; state <= S_ROOT;
              end
            end
            imh_pkg::OP_EXTRACT: begin
              if (cnt == '0) status <= imh_pkg::ST_EMPTY;
              else begin
                extracted <= 1'b1; state <= S_EXT;
              end
            end
            default: ;
          endcase
        end
        S_ROOT: begin
          state <= S_FIN_W; rd_phase <= 3'd7;
        end
        S_SET: state <= S_UP_RD;
        S_UP_RD: begin
          if (cur == '0) begin
            if (after == AF_DONE) state <= S_FIN;
            else state <= S_EXT;
          end else begin
            other <= (cur - (AW+1)'(1)) >> 1;
            state <= S_UP_W1;
          end
        end
        S_UP_W1: begin
          kc <= hs_rd;
          state <= S_UP_W2;
        end
        S_UP_W2: begin
          kl <= hs_rd;
          state <= S_UP_CMP;
          vl <= $signed(kv_rd);
        end
        S_UP_CMP: begin
          // vl: value at cur; kv_rd: parent value
          if ($signed(kv_rd) >= vl) state <= S_UP_SW;
          else if (after == AF_DONE) state <= S_FIN;
          else state <= S_EXT;
        end
        S_UP_SW: state <= S_UP_SW2;
        S_UP_SW2: begin
          cur <= other; state <= S_UP_RD;
        end
        S_EXT: state <= S_EXT_W;
        S_EXT_W: begin
          ok_key <= hs_rd;
          cnt <= cnt - CW'(1);
          state <= S_EXT_W2;
        end
        S_EXT_W2: begin
          ok_val <= $signed(kv_rd);
          cur <= '0;
          rd_phase <= 3'd0;
          if (cnt == '0) state <= (after == AF_REINSERT) ? S_INS : S_FIN;
          else state <= S_DN_RD;
        end
        S_DN_RD: begin
          if (lchild >= {1'b0, cnt}) state <= (after == AF_REINSERT) ? S_INS : S_FIN;
          else state <= S_DN_W;
        end
        S_DN_W: begin
          case (rd_phase)
            3'd0: begin
              kc <= hs_rd; rd_phase <= 3'd1; state <= S_DN_RD;
            end
            3'd1: begin
              vc <= $signed(kv_rd); kl <= hs_rd; rd_phase <= 3'd2; state <= S_DN_RD;
            end
            3'd2: begin
              vl <= $signed(kv_rd); kr <= hs_rd; rd_phase <= 3'd3;
              state <= (rchild < {1'b0, cnt}) ? S_DN_W : S_DN_CMP;
            end
            default: begin
              vr <= $signed(kv_rd); rd_phase <= 3'd4; state <= S_DN_CMP;
            end
          endcase
        end
        S_DN_CMP: begin
          rd_phase <= 3'd0;
          if (rd_phase == 3'd4) begin
            if (vc <= vl && vc <= vr)
              state <= (after == AF_REINSERT) ? S_INS : S_FIN;
            else if (vl < vr) begin
              other <= lchild; state <= S_DN_SW;
            end else begin
              other <= rchild; kl <= kr; state <= S_DN_SW;
            end
          end else if (vc <= vl) state <= (after == AF_REINSERT) ? S_INS : S_FIN;
          else begin
            other <= lchild; state <= S_DN_SW;
          end
        end
        S_DN_SW: state <= S_DN_SW2;
        S_DN_SW2: begin
          cur <= other; state <= S_DN_RD;
        end
        S_INS: begin
          cur <= {1'b0, cnt[AW-1:0]};
          cnt <= cnt + CW'(1);
          after <= AF_DONE;
          state <= S_UP_RD;
        end
        S_FIN: begin
          rd_phase <= 3'd0;
          state <= S_FIN_W;
        end
        S_FIN_W: begin
          if (rd_phase == 3'd7) begin
            // wait for the root value
            rd_phase <= 3'd6; state <= S_FIN_W;
          end else if (rd_phase == 3'd6) begin
            // lower key to min-1
            state <= S_SET; nv <= minm1;
            rd_phase <= 3'd0;
          end else begin
            kc <= hs_rd; state <= S_FIN_W2;
          end
        end
        S_FIN_W2: begin
          m_tvalid <= 1'b1;
          if (!extracted) begin
            ok_key <= (cnt == '0) ? '0 : kc;
            ok_val <= (cnt == '0) ? '0 : $signed(kv_rd);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_tvalid && m_tready) begin
            m_tvalid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DISP) saved_nv <= (op == imh_pkg::OP_DECREASE) ? dec_val : nv;
  end

  logic pres_q;
  always_ff @(posedge clk) begin
    if (state == S_FIN_W && rd_phase != 3'd7 && rd_phase != 3'd6) pres_q <= pr_rd && key_ok;
  end

  logic [55:0] out_word;
  always_comb begin
    out_word = '0;
    out_word[9:0]   = ok_key;
    out_word[41:10] = 32'(ok_val);
    out_word[52:42] = 11'(cnt);
    out_word[53]    = pres_q;
    out_word[55:54] = status;
  end
  assign m_tdata = out_word;

  a_cnt_cap: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(CAPACITY))
    else $error("count above capacity");
  a_ready: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(cnt))
    else $error("result dropped");
endmodule
